@@ hw/rtl/smcsr_pkg.sv @@
// ============================================================================
// smcsr_pkg
// Shared widths, command codes and store port types for the sparse matrix
// compressed-row store.
// ============================================================================
package smcsr_pkg;

    // Field widths
    localparam int CMD_W = 2;
    localparam int ROW_W = 10;
    localparam int COL_W = 16;
    localparam int VAL_W = 32;

    // Number of rows the row field can address
    localparam int ROW_SPAN = 1 << ROW_W;

    // Widest store port fields over the whole parameter range
    localparam int ENT_AW_MAX = 16;
    localparam int CNT_W_MAX  = 17;
    localparam int ROW_AW_MAX = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Sequencer to store
    typedef struct packed {
        logic                  row_we;
        logic [ROW_AW_MAX-1:0] row_addr;
        logic [CNT_W_MAX-1:0]  row_wdata;
        logic                  ent_we;
        logic [ENT_AW_MAX-1:0] ent_addr;
        logic [VAL_W-1:0]      ent_value;
        logic [COL_W-1:0]      ent_column;
    } store_req_t;

    // Store to sequencer (registered read data)
    typedef struct packed {
        logic [CNT_W_MAX-1:0] row_q;
        logic [VAL_W-1:0]     value_q;
        logic [COL_W-1:0]     column_q;
    } store_rsp_t;

endpackage

@@ hw/rtl/smcsr_req_if.sv @@
// ============================================================================
// smcsr_req_if
// Request channel: command, position and value of one beat.
// ============================================================================
interface smcsr_req_if;

    logic                              valid;
    logic                              ready;
    logic [smcsr_pkg::CMD_W-1:0]       command;
    logic [smcsr_pkg::ROW_W-1:0]       row_index;
    logic [smcsr_pkg::COL_W-1:0]       col_index;
    logic signed [smcsr_pkg::VAL_W-1:0] entry_value;

    modport source (
        output valid, command, row_index, col_index, entry_value,
        input  ready
    );

    modport sink (
        input  valid, command, row_index, col_index, entry_value,
        output ready
    );

endinterface

@@ hw/rtl/smcsr_resp_if.sv @@
// ============================================================================
// smcsr_resp_if
// Response channel: looked-up value and hit flag of one beat.
// ============================================================================
interface smcsr_resp_if;

    logic                               valid;
    logic                               ready;
    logic signed [smcsr_pkg::VAL_W-1:0] result_value;
    logic                               present;

    modport source (
        output valid, result_value, present,
        input  ready
    );

    modport sink (
        input  valid, result_value, present,
        output ready
    );

endinterface

@@ hw/rtl/smcsr_store.sv @@
// ============================================================================
// smcsr_store
// Value, column and row-start memories, single port each, registered read.
// ============================================================================
module smcsr_store #(
    parameter int MAX_ENTRIES = 1024,
    parameter int ROW_DEPTH   = 1025
) (
    input  logic                  clk,
    input  smcsr_pkg::store_req_t req,
    output smcsr_pkg::store_rsp_t rsp
);

    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int RAW = $clog2(ROW_DEPTH);

    logic [smcsr_pkg::VAL_W-1:0] value_mem  [MAX_ENTRIES];
    logic [smcsr_pkg::COL_W-1:0] column_mem [MAX_ENTRIES];
    logic [CW-1:0]               row_mem    [ROW_DEPTH];

    logic [smcsr_pkg::VAL_W-1:0] value_q_reg;
    logic [smcsr_pkg::COL_W-1:0] column_q_reg;
    logic [CW-1:0]               row_q_reg;

    logic [EAW-1:0] ent_addr;
    logic [RAW-1:0] row_addr;

    assign ent_addr = EAW'(req.ent_addr);
    assign row_addr = RAW'(req.row_addr);

    // Entry memories: write on load, read every cycle
    always_ff @(posedge clk)
    begin
        if (req.ent_we)
        begin
            value_mem[ent_addr]  <= req.ent_value;
            column_mem[ent_addr] <= req.ent_column;
        end
        value_q_reg  <= value_mem[ent_addr];
        column_q_reg <= column_mem[ent_addr];
    end

    // Row-start memory
    always_ff @(posedge clk)
    begin
        if (req.row_we)
        begin
            row_mem[row_addr] <= CW'(req.row_wdata);
        end
        row_q_reg <= row_mem[row_addr];
    end

    assign rsp.row_q    = smcsr_pkg::CNT_W_MAX'(row_q_reg);
    assign rsp.value_q  = value_q_reg;
    assign rsp.column_q = column_q_reg;

endmodule

@@ hw/rtl/sparse_matrix_csr_store_lookup.sv @@
// ============================================================================
// sparse_matrix_csr_store_lookup
// Compressed-sparse-row matrix store: appends ordered entries and answers
// point lookups by scanning the stored columns of one row.
// ============================================================================
//
//  channel | modport | beat carries                                | results
//  --------+---------+---------------------------------------------+--------
//  req     | sink    | command, row_index, col_index, entry_value  | -
//  resp    | source  | result_value, present                       | 1/query
//
//  Load: one row-start write per cycle through the single row-start port,
//  from the row after the largest one to the row after the entry's row,
//  then the entry; after an empty store the walk starts at row 0.
//  Ignored loads, clear and unused codes leave the sequencer idle.
//  Query: answered without the store when it is empty or the row or column
//  is beyond the largest stored one; else the stored columns of the row are
//  compared in turn, stopping at the first at or above the requested one.
//  Reset empties the store at once; memories are not swept.
//  req is held off while a beat is in work and while a finished result
//  cannot enter the response register.
// ============================================================================
module sparse_matrix_csr_store_lookup #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    smcsr_req_if.sink    req,
    smcsr_resp_if.source resp
);

    localparam int ROW_LIMIT = (MAX_ROWS < smcsr_pkg::ROW_SPAN) ? MAX_ROWS
                                                               : smcsr_pkg::ROW_SPAN;
    localparam int ROW_DEPTH = ROW_LIMIT + 1;
    localparam int CW        = $clog2(MAX_ENTRIES + 1);
    localparam int RAW       = $clog2(ROW_DEPTH);
    localparam int IW        = smcsr_pkg::CNT_W_MAX;
    localparam int RW        = smcsr_pkg::ROW_W;
    localparam int LW        = smcsr_pkg::ROW_AW_MAX;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RLO  = 3'd2;
    localparam logic [2:0] S_RHI  = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    // Latched beat
    logic [RW-1:0]                  row_reg, row_next;
    logic [smcsr_pkg::COL_W-1:0]    col_reg, col_next;
    logic [smcsr_pkg::VAL_W-1:0]    val_reg, val_next;

    // Store bookkeeping
    logic [CW-1:0]                  entry_count_reg, entry_count_next;
    logic [RW-1:0]                  largest_row_reg, largest_row_next;
    logic [smcsr_pkg::COL_W-1:0]    largest_column_reg, largest_column_next;
    logic [smcsr_pkg::COL_W-1:0]    last_column_reg, last_column_next;
    logic                           store_empty_reg, store_empty_next;

    // Walk pointers
    logic [RAW-1:0]                 k_reg, k_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic [CW-1:0]                  hi_reg, hi_next;

    // Lookup result
    logic                           found_reg, found_next;
    logic [smcsr_pkg::VAL_W-1:0]    found_value_reg, found_value_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_present_reg, out_present_next;
    logic [smcsr_pkg::VAL_W-1:0]    out_value_reg, out_value_next;

    // Shared incrementer
    logic [IW-1:0]                  inc_in;
    logic [IW-1:0]                  inc_out;

    logic                           fill_final;
    logic                           accept;
    logic                           load_ok;
    logic                           query_out;

    smcsr_pkg::store_req_t          st_req;
    smcsr_pkg::store_rsp_t          st_rsp;

    smcsr_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ROW_DEPTH   (ROW_DEPTH)
    ) u_store (
        .clk (clk),
        .req (st_req),
        .rsp (st_rsp)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign accept            = req.valid && req.ready;
    assign resp.valid        = out_valid_reg;
    assign resp.result_value = out_value_reg;
    assign resp.present      = out_present_reg;

    // Last row-start write of a load: pointer has passed the entry's row
    assign fill_final = (LW'(k_reg) > LW'(row_reg));

    // Order, range and capacity checks on a load beat
    always_comb
    begin
        load_ok = (LW'(req.row_index) < LW'(ROW_LIMIT));
        if (!store_empty_reg)
        begin
            if (entry_count_reg >= CW'(MAX_ENTRIES))
            begin
                load_ok = 1'b0;
            end
            if (req.row_index < largest_row_reg)
            begin
                load_ok = 1'b0;
            end
            if ((req.row_index == largest_row_reg) && (req.col_index <= last_column_reg))
            begin
                load_ok = 1'b0;
            end
        end
    end

    // Query answered without touching the store
    assign query_out = store_empty_reg || (req.row_index > largest_row_reg) ||
                       (req.col_index > largest_column_reg);

    // Select the operand of the shared incrementer
    always_comb
    begin
        case (state_reg)
            S_IDLE:  inc_in = IW'(largest_row_reg);
            S_FILL:  inc_in = fill_final ? IW'(entry_count_reg) : IW'(k_reg);
            S_RHI:   inc_in = IW'(row_reg);
            default: inc_in = IW'(ptr_reg);
        endcase
    end

    assign inc_out = inc_in + IW'(1);

    // Drive the store ports
    always_comb
    begin
        st_req.row_we     = (state_reg == S_FILL);
        st_req.row_wdata  = fill_final ? inc_out : IW'(entry_count_reg);
        st_req.ent_we     = (state_reg == S_FILL) && fill_final;
        st_req.ent_value  = val_reg;
        st_req.ent_column = col_reg;
        case (state_reg)
            S_FILL:  st_req.row_addr = LW'(k_reg);
            S_RHI:   st_req.row_addr = LW'(inc_out);
            default: st_req.row_addr = LW'(row_reg);
        endcase
        if (state_reg == S_FILL)
        begin
            st_req.ent_addr = smcsr_pkg::ENT_AW_MAX'(entry_count_reg);
        end
        else
        begin
            st_req.ent_addr = smcsr_pkg::ENT_AW_MAX'(ptr_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next          = state_reg;
        row_next            = row_reg;
        col_next            = col_reg;
        val_next            = val_reg;
        entry_count_next    = entry_count_reg;
        largest_row_next    = largest_row_reg;
        largest_column_next = largest_column_reg;
        last_column_next    = last_column_reg;
        store_empty_next    = store_empty_reg;
        k_next              = k_reg;
        ptr_next            = ptr_reg;
        hi_next             = hi_reg;
        found_next          = found_reg;
        found_value_next    = found_value_reg;
        out_valid_next      = out_valid_reg;
        out_present_next    = out_present_reg;
        out_value_next      = out_value_reg;

        // Drop the response once taken
        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next = req.row_index;
                    col_next = req.col_index;
                    val_next = req.entry_value;
                    case (req.command)
                        smcsr_pkg::CMD_LOAD:
                        begin
                            if (load_ok)
                            begin
                                k_next     = store_empty_reg ? '0 : RAW'(inc_out);
                                state_next = S_FILL;
                            end
                        end
                        smcsr_pkg::CMD_QUERY:
                        begin
                            found_next       = 1'b0;
                            found_value_next = '0;
                            state_next       = query_out ? S_DONE : S_RLO;
                        end
                        smcsr_pkg::CMD_CLEAR:
                        begin
                            entry_count_next    = '0;
                            largest_row_next    = '0;
                            largest_column_next = '0;
                            last_column_next    = '0;
                            store_empty_next    = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Write row starts up to the entry's row, then the entry itself
            S_FILL:
            begin
                if (fill_final)
                begin
                    entry_count_next = CW'(inc_out);
                    largest_row_next = row_reg;
                    last_column_next = col_reg;
                    if (store_empty_reg || (col_reg > largest_column_reg))
                    begin
                        largest_column_next = col_reg;
                    end
                    store_empty_next = 1'b0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    k_next = RAW'(inc_out);
                end
            end

            // Row start of the queried row is being read
            S_RLO:
            begin
                state_next = S_RHI;
            end

            // Capture row start, read the next row's start
            S_RHI:
            begin
                ptr_next   = CW'(st_rsp.row_q);
                state_next = S_HI;
            end

            S_HI:
            begin
                hi_next    = CW'(st_rsp.row_q);
                state_next = S_SCAN;
            end

            // Read the next stored column of the row, or stop at row end
            S_SCAN:
            begin
                state_next = (ptr_reg < hi_reg) ? S_CMP : S_DONE;
            end

            // Compare the stored column; columns rise within a row
            S_CMP:
            begin
                if (st_rsp.column_q == col_reg)
                begin
                    found_next       = 1'b1;
                    found_value_next = st_rsp.value_q;
                    state_next       = S_DONE;
                end
                else if (st_rsp.column_q > col_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = CW'(inc_out);
                    state_next = S_SCAN;
                end
            end

            // Hand the result to the response register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_present_next = found_reg;
                    out_value_next   = found_value_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            entry_count_reg    <= '0;
            largest_row_reg    <= '0;
            largest_column_reg <= '0;
            last_column_reg    <= '0;
            store_empty_reg    <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            entry_count_reg    <= entry_count_next;
            largest_row_reg    <= largest_row_next;
            largest_column_reg <= largest_column_next;
            last_column_reg    <= last_column_next;
            store_empty_reg    <= store_empty_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        col_reg         <= col_next;
        val_reg         <= val_next;
        k_reg           <= k_next;
        ptr_reg         <= ptr_next;
        hi_reg          <= hi_next;
        found_reg       <= found_next;
        found_value_reg <= found_value_next;
        out_present_reg <= out_present_next;
        out_value_reg   <= out_value_next;
    end

endmodule
